### src/vmd_pkg.sv
// shared types, widths and helper functions of the voxel majority downsampler
package vmd_pkg;

   localparam int ID_W     = 8;
   localparam int CNT_W    = 10;
   localparam int FACTOR_W = 4;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(2);

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [CNT_W-1:0] count;
   } best_type;

   typedef struct packed {
      logic             en;
      logic [ID_W-1:0]  addr;
      logic [CNT_W-1:0] data;
   } store_wr_type;

   function automatic logic [CNT_W-1:0] cube_of(input logic [FACTOR_W-1:0] f);
      logic [CNT_W-1:0] r;
      case (f)
         FACTOR_W'(1): r = CNT_W'(1);
         FACTOR_W'(2): r = CNT_W'(8);
         FACTOR_W'(3): r = CNT_W'(27);
         FACTOR_W'(4): r = CNT_W'(64);
         FACTOR_W'(5): r = CNT_W'(125);
         FACTOR_W'(6): r = CNT_W'(216);
         FACTOR_W'(7): r = CNT_W'(343);
         FACTOR_W'(8): r = CNT_W'(512);
         default:      r = CNT_W'(1);
      endcase
      return r;
   endfunction

endpackage

### src/vmd_ifs.sv
// channel interfaces: voxel beats in, result beats out, factor writes
interface vmd_req_if import vmd_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] voxel_id;

   modport source (output valid, output voxel_id, input ready);
   modport sink   (input valid, input voxel_id, output ready);
endinterface

interface vmd_rsp_if import vmd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ID_W-1:0]  mode_id;
   logic [CNT_W-1:0] mode_count;

   modport source (output valid, output mode_id, output mode_count, input ready);
   modport sink   (input valid, input mode_id, input mode_count, output ready);
endinterface

interface vmd_csr_if import vmd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FACTOR_W-1:0] reduction_factor;

   modport source (output valid, output reduction_factor, input ready);
   modport sink   (input valid, input reduction_factor, output ready);
endinterface

### src/vmd_count_store.sv
// per-id counter memory with flip-flop valid bits that clear a whole group at once
module vmd_count_store import vmd_pkg::*; #(
   parameter int ID_COUNT = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             rd_en,
   input  logic [ID_W-1:0]  rd_addr,
   input  store_wr_type     wr,
   output logic [CNT_W-1:0] rd_count
);

   localparam int AW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;

   logic [CNT_W-1:0]    mem [ID_COUNT];
   logic [ID_COUNT-1:0] valid_ff;
   logic [CNT_W-1:0]    rd_data_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr[AW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr[AW-1:0]];
      end
   end

   assign rd_count = rd_valid_ff ? rd_data_ff : '0;

endmodule

### src/vmd_tally.sv
// shared increment and compare unit: bumps one counter, updates the winner
module vmd_tally import vmd_pkg::*; #(
   parameter int ID_COUNT = 256
) (
   input  logic [ID_W-1:0]  id,
   input  logic [CNT_W-1:0] cur_count,
   input  best_type         best,
   input  logic [CNT_W-1:0] voxels_seen,
   input  logic [CNT_W-1:0] group_size,
   output logic             counted,
   output logic [CNT_W-1:0] new_count,
   output best_type         new_best,
   output logic [CNT_W-1:0] new_seen,
   output logic             done
);

   localparam logic [ID_W:0] ID_LIMIT = (ID_W + 1)'(ID_COUNT);

   logic better;

   always_comb begin
      counted   = (id != '0) && ({1'b0, id} < ID_LIMIT);
      new_count = cur_count + CNT_W'(1);
      better    = (new_count > best.count) ||
                  ((new_count == best.count) && (id < best.id));
      new_best  = best;
      if (counted && better) begin
         new_best.id    = id;
         new_best.count = new_count;
      end
      new_seen = voxels_seen + CNT_W'(1);
      done     = (new_seen >= group_size);
   end

endmodule

### src/voxel_majority_downsample.sv
// top level of the voxel majority downsampler: sequencer, winner and result register
//
// req_if takes one voxel id per beat; the ids arrive grouped, factor cubed
// voxels to a coarse cell. rsp_if gives one beat per finished group: the
// most frequent non-air id (lowest id on ties) and its count, or id 0 with
// count 0 for an all-air group. csr_if writes the reduction factor (0 acts
// as 1, values above MAX_FACTOR saturate); a write drops any partial group.
// csr_if.ready is high only between voxels, and req_if.ready stays low
// while a factor write is offered.
// Each voxel passes through a registered counter read at accept, then the
// increment, compare and write-back through the shared tally unit;
// req_if.ready is low during the latter. The result beat is written at the
// end of the last voxel's update and sits in an output register,
// so the next group can start while it waits. If a group ends while the
// previous result is still stalled, the sequencer holds until rsp_if.ready.
// Reset clears the counters at once through per-id valid bits, sets the
// factor to 2 and empties the result register; no clearing pass is needed.
module voxel_majority_downsample import vmd_pkg::*; #(
   parameter int ID_COUNT   = 256,
   parameter int MAX_FACTOR = 8
) (
   input  logic       clock,
   input  logic       reset,
   vmd_req_if.sink    req_if,
   vmd_rsp_if.source  rsp_if,
   vmd_csr_if.sink    csr_if
);

   localparam logic [FACTOR_W-1:0] MAX_F = FACTOR_W'(MAX_FACTOR);

   state_type        state_ff, state_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [CNT_W-1:0] voxels_seen_ff, voxels_seen_in;
   best_type         best_ff, best_in;
   logic [CNT_W-1:0] group_size_ff, group_size_in;
   logic             rsp_valid_ff, rsp_valid_in;
   best_type         rsp_ff, rsp_in;

   logic             csr_write;
   logic             accept;
   logic             out_free;
   logic             clear;
   logic [FACTOR_W-1:0] f_sat;
   store_wr_type     wr;
   logic [CNT_W-1:0] cur_count;
   logic             counted;
   logic [CNT_W-1:0] new_count;
   best_type         new_best;
   logic [CNT_W-1:0] new_seen;
   logic             done;

   vmd_count_store #(.ID_COUNT(ID_COUNT)) u_store (
      .clock    (clock),
      .reset    (reset),
      .clear    (clear),
      .rd_en    (accept),
      .rd_addr  (req_if.voxel_id),
      .wr       (wr),
      .rd_count (cur_count)
   );

   vmd_tally #(.ID_COUNT(ID_COUNT)) u_tally (
      .id          (id_ff),
      .cur_count   (cur_count),
      .best        (best_ff),
      .voxels_seen (voxels_seen_ff),
      .group_size  (group_size_ff),
      .counted     (counted),
      .new_count   (new_count),
      .new_best    (new_best),
      .new_seen    (new_seen),
      .done        (done)
   );

   assign csr_if.ready = (state_ff == ST_IDLE);
   assign csr_write    = csr_if.valid && (state_ff == ST_IDLE);
   assign req_if.ready = (state_ff == ST_IDLE) && !csr_if.valid;
   assign accept       = req_if.valid && (state_ff == ST_IDLE) && !csr_if.valid;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.mode_id    = rsp_ff.id;
   assign rsp_if.mode_count = rsp_ff.count;

   always_comb begin
      if (csr_if.reduction_factor == '0) begin
         f_sat = FACTOR_W'(1);
      end else if (csr_if.reduction_factor > MAX_F) begin
         f_sat = MAX_F;
      end else begin
         f_sat = csr_if.reduction_factor;
      end
   end

   always_comb begin
      state_in       = state_ff;
      id_in          = id_ff;
      voxels_seen_in = voxels_seen_ff;
      best_in        = best_ff;
      group_size_in  = group_size_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_in         = rsp_ff;
      clear          = 1'b0;
      wr.en          = 1'b0;
      wr.addr        = id_ff;
      wr.data        = new_count;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               id_in    = req_if.voxel_id;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!done || out_free) begin
               wr.en    = counted;
               state_in = ST_IDLE;
               if (done) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in         = new_best;
                  clear          = 1'b1;
                  voxels_seen_in = '0;
                  best_in        = '0;
               end else begin
                  voxels_seen_in = new_seen;
                  best_in        = new_best;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         group_size_in  = cube_of(f_sat);
         clear          = 1'b1;
         voxels_seen_in = '0;
         best_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         voxels_seen_ff <= '0;
         best_ff        <= '0;
         group_size_ff  <= cube_of(FACTOR_RESET);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         voxels_seen_ff <= voxels_seen_in;
         best_ff        <= best_in;
         group_size_ff  <= group_size_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      rsp_ff <= rsp_in;
   end

endmodule

### sim/tb_voxel_majority_downsample.sv
// testbench of the voxel majority downsampler: drives voxel beats and factor writes, checks modes
module tb_voxel_majority_downsample import vmd_pkg::*; ();

   localparam int MAX_EDGE      = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;

   class majority_tracker;
      logic [CNT_W-1:0]    tally [256];
      int                  voxels_in_group;
      best_type            leader;
      logic [FACTOR_W-1:0] factor;
      best_type            expected_modes [$];
      int                  errors;
      int                  voxels;
      int                  results;
      int                  factor_writes;

      function new();
         factor = FACTOR_RESET;
         restart_group();
      endfunction

      function void restart_group();
         foreach (tally[i]) tally[i] = '0;
         voxels_in_group = 0;
         leader = '0;
      endfunction

      function void set_factor(input logic [FACTOR_W-1:0] f);
         factor = f;
         factor_writes++;
         restart_group();
      endfunction

      function int group_len();
         int f;
         f = int'(factor);
         if (f == 0) f = 1;
         if (f > MAX_EDGE) f = MAX_EDGE;
         return f * f * f;
      endfunction

      function void take_voxel(input logic [ID_W-1:0] id);
         logic [CNT_W-1:0] c;
         voxels++;
         if (id != '0) begin
            c = tally[id] + 1'b1;
            tally[id] = c;
            if (c > leader.count || (c == leader.count && id < leader.id)) begin
               leader.id    = id;
               leader.count = c;
            end
         end
         voxels_in_group++;
         if (voxels_in_group >= group_len()) begin
            expected_modes.insert(expected_modes.size(), leader);
            restart_group();
         end
      endfunction

      function void match_result(input logic [ID_W-1:0] id, input logic [CNT_W-1:0] count);
         best_type want;
         results++;
         if (expected_modes.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, actual id %0d count %0d",
                     $time, id, count);
            return;
         end
         want = expected_modes.pop_front();
         if (id !== want.id) begin
            errors++;
            $display("%0t: mode_id mismatch, expected %0d, actual %0d", $time, want.id, id);
         end
         if (count !== want.count) begin
            errors++;
            $display("%0t: mode_count mismatch, expected %0d, actual %0d",
                     $time, want.count, count);
         end
      endfunction

      function int pending();
         return expected_modes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   vmd_req_if req_if ();
   vmd_rsp_if rsp_if ();
   vmd_csr_if csr_if ();

   voxel_majority_downsample DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   majority_tracker board = new();

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int quiet_cycles  = 0;

   logic [ID_W-1:0] directed_ids [24] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd9,   8'd4,   8'd9,   8'd4,   8'd0,   8'd0,   8'd255, 8'd255,
      8'd255, 8'd1,   8'd255, 8'd255, 8'd1,   8'd255, 8'd255, 8'd0
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         board.match_result(rsp_if.mode_id, rsp_if.mode_count);
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
          (csr_if.valid === 1'b1 && csr_if.ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_voxel(input logic [ID_W-1:0] id);
      req_if.valid    <= 1'b1;
      req_if.voxel_id <= id;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      board.take_voxel(id);
   endtask

   task automatic write_factor(input logic [FACTOR_W-1:0] f);
      csr_if.valid            <= 1'b1;
      csr_if.reduction_factor <= f;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      board.set_factor(f);
      csr_if.valid <= 1'b0;
   endtask

   task automatic hold_for_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic drain_and_settle();
      hold_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [ID_W-1:0] pick_voxel(input logic [ID_W-1:0] palette [3]);
      int r;
      r = $urandom_range(99);
      if (r < 15) return ID_W'($urandom_range(255));
      if (r < 30) return '0;
      return palette[$urandom_range(2)];
   endfunction

   task automatic run_phase(input logic [FACTOR_W-1:0] f, input int items,
                            input int idle_pct, input int stall);
      logic [ID_W-1:0] palette [3];
      int              n;
      drain_and_settle();
      write_factor(f);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      for (n = 0; n < items; n++) begin
         if (n % board.group_len() == 0) begin
            foreach (palette[i]) palette[i] = ID_W'($urandom_range(255, 1));
         end
         if (n == items / 2) hold_for_results();
         while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
         send_voxel(pick_voxel(palette));
      end
   endtask

   initial begin
      reset                   <= 1'b1;
      req_if.valid            <= 1'b0;
      req_if.voxel_id         <= '0;
      csr_if.valid            <= 1'b0;
      csr_if.reduction_factor <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset factor: all-air group, three-way tie, clear winner
      foreach (directed_ids[i]) send_voxel(directed_ids[i]);

      run_phase(4'd0,  50,  84, 0);
      run_phase(4'd1,  60,  0,  84);
      run_phase(4'd2,  124, 23, 23);
      run_phase(4'd3,  54,  0,  0);
      run_phase(4'd15, 40,  84, 0);
      run_phase(4'd8,  512, 0,  84);
      run_phase(4'd4,  64,  23, 23);
      run_phase(4'd5,  125, 0,  0);
      drain_and_settle();

      if (board.pending() != 0)
         $display("%0t: %0d expected result beats never arrived, expected 0 left, actual %0d",
                  $time, board.pending(), board.pending());
      $display("run covered %0d voxel beats, %0d result beats, %0d factor writes (0 to 15)",
               board.voxels, board.results, board.factor_writes);
      $display("with ties, all-air groups, dropped partial groups and all idle/stall mixes");
      if (board.errors == 0 && board.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
